FILE: design/fpha_pkg.sv
// ----------------------------------------------------------------------------
// fpha_pkg
// Shared types and codes for the fit-policy heap allocator: table entry
// layout, result status codes, policy codes and controller/datapath bundles.
// ----------------------------------------------------------------------------
package fpha_pkg;

  // external field width and internal byte-count width
  localparam int FLD_W = 26;
  localparam int SZ_W  = 27;

  // operation kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // placement rules; the spare code places like first fit
  localparam logic [1:0] POL_FIRST  = 2'd0;
  localparam logic [1:0] POL_BEST   = 2'd1;
  localparam logic [1:0] POL_WORST  = 2'd2;
  localparam logic [1:0] POL_UNUSED = 2'd3;

  // result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;
  localparam logic [1:0] ST_ZERO    = 2'd3;

  // one block table entry
  typedef struct packed {
    logic [SZ_W-1:0] start;
    logic [SZ_W-1:0] size;
    logic            free;
  } blk_t;

  // controller to datapath
  typedef struct packed {
    logic init;
    logic accept;
    logic scan;
    logic decide;
    logic move;
    logic wr_new;
    logic wr_main;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic zero_in;
    logic scan_done;
    logic fail;
    logic split;
    logic is_alloc;
    logic mv_done;
    logic out_free;
  } sts_t;

endpackage

FILE: design/fpha_ctrl.sv
// ----------------------------------------------------------------------------
// fpha_ctrl
// Sequencer for the allocator: reset fill, table scan, decision, entry
// shifting, entry writes and result hand-off.
// ----------------------------------------------------------------------------
module fpha_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  fpha_pkg::sts_t sts,
  output fpha_pkg::cmd_t cmd
);
  import fpha_pkg::*;

  typedef enum logic [7:0] {
    S_INIT   = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_DECIDE = 8'b0000_1000,
    S_MOVE   = 8'b0001_0000,
    S_WNEW   = 8'b0010_0000,
    S_WMAIN  = 8'b0100_0000,
    S_RESP   = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:   state_next = S_IDLE;
      S_IDLE:   if (accept) state_next = sts.zero_in ? S_RESP : S_SCAN;
      S_SCAN:   if (sts.scan_done) state_next = S_DECIDE;
      S_DECIDE: begin
        priority if (sts.fail) state_next = S_RESP;
        else if (sts.is_alloc && sts.split) state_next = S_MOVE;
        else state_next = S_WMAIN;
      end
      S_MOVE:   if (sts.mv_done) state_next = sts.is_alloc ? S_WNEW : S_RESP;
      S_WNEW:   state_next = S_WMAIN;
      S_WMAIN:  state_next = sts.is_alloc ? S_RESP : S_MOVE;
      S_RESP:   if (sts.out_free) state_next = S_IDLE;
      default:  state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // commands
  always_comb begin
    cmd          = '0;
    cmd.init     = (state == S_INIT);
    cmd.accept   = accept;
    cmd.scan     = (state == S_SCAN);
    cmd.decide   = (state == S_DECIDE);
    cmd.move     = (state == S_MOVE);
    cmd.wr_new   = (state == S_WNEW);
    cmd.wr_main  = (state == S_WMAIN);
    cmd.load_out = (state == S_RESP) && sts.out_free;
  end

endmodule

FILE: design/fpha_dpath.sv
// ----------------------------------------------------------------------------
// fpha_dpath
// Block table memory, scan trackers, split/merge arithmetic, entry shift
// engine, policy register and result register.
// ----------------------------------------------------------------------------
module fpha_dpath #(
  parameter int HEAP_BYTES   = 67108864,
  parameter int HEADER_BYTES = 32,
  parameter int TAG_BYTES    = 8,
  parameter int MAX_BLOCKS   = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  fpha_pkg::cmd_t            cmd,
  output fpha_pkg::sts_t            sts,
  input  logic                      cfg_valid,
  input  logic [1:0]                fit_policy,
  input  logic                      kind,
  input  logic [fpha_pkg::FLD_W-1:0] request_size,
  input  logic [fpha_pkg::FLD_W-1:0] payload_offset,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [fpha_pkg::FLD_W-1:0] result_offset,
  output logic [1:0]                status,
  output logic [fpha_pkg::FLD_W-1:0] allocated_total
);
  import fpha_pkg::*;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = IDX_W + 1;
  localparam logic [SZ_W-1:0]  HDR       = SZ_W'(HEADER_BYTES);
  localparam logic [SZ_W-1:0]  GAP       = SZ_W'(HEADER_BYTES + TAG_BYTES);
  localparam logic [SZ_W-1:0]  SPLIT_MIN = SZ_W'(HEADER_BYTES + TAG_BYTES + 4);
  localparam logic [SZ_W-1:0]  INIT_SIZE = SZ_W'(HEAP_BYTES - HEADER_BYTES - TAG_BYTES);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);

  // block table
  blk_t mem [MAX_BLOCKS];
  blk_t rdata;
  logic             re, we;
  logic [IDX_W-1:0] raddr, waddr;
  blk_t             wdata;

  // architectural state
  logic [CNT_W-1:0] count;
  logic [FLD_W-1:0] total;
  logic [1:0]       pol;

  // accepted item
  logic             kind_r;
  logic [SZ_W-1:0]  need;
  logic [SZ_W-1:0]  off_r;

  // scan
  logic [CNT_W-1:0] scan_idx;
  logic             scan_issue;
  logic             rd_scan;
  logic [IDX_W-1:0] rd_idx;
  logic             have;
  logic [IDX_W-1:0] pidx;
  logic [SZ_W-1:0]  pstart, psize;
  logic             found, prev_ok, nxt_ok;
  logic [IDX_W-1:0] cidx;
  blk_t             cur, prev, nxt, last;
  logic             fits, take, hit, grab_nxt;

  // decision
  logic [SZ_W-1:0]  rem, sz_n, sz_p, sz_pn;
  logic             split, mrg_n, mrg_p, fail;
  logic [CNT_W-1:0] pidx_e, cidx_e;
  logic [IDX_W-1:0] main_addr_d, new_addr_d, mv_src_d;
  blk_t             main_d, new_d;
  logic [CNT_W-1:0] mv_left_d, count_d;
  logic             mv_up_d, mv_two_d;
  logic [FLD_W-1:0] total_d;
  logic [FLD_W-1:0] res_off_d;
  logic [1:0]       res_st_d;

  // latched decision
  logic [IDX_W-1:0] main_addr, new_addr;
  blk_t             main_e, new_e;
  logic [FLD_W-1:0] res_off;
  logic [1:0]       res_st;

  // shift engine
  logic [IDX_W-1:0] mv_src, pend_addr, mv_dst;
  logic [CNT_W-1:0] mv_left;
  logic             mv_up, mv_two, mv_issue, pend;

  // ---------------- table memory ----------------
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  assign scan_issue = cmd.scan && (scan_idx < count);
  assign mv_issue   = cmd.move && (mv_left != '0);
  assign re         = scan_issue || mv_issue;
  assign raddr      = scan_issue ? scan_idx[IDX_W-1:0] : mv_src;

  // single write port
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    priority if (cmd.init) begin
      we    = 1'b1;
      wdata = '{start: '0, size: INIT_SIZE, free: 1'b1};
    end else if (pend) begin
      we    = 1'b1;
      waddr = pend_addr;
      wdata = rdata;
    end else if (cmd.wr_new) begin
      we    = 1'b1;
      waddr = new_addr;
      wdata = new_e;
    end else if (cmd.wr_main) begin
      we    = 1'b1;
      waddr = main_addr;
      wdata = main_e;
    end else begin
      we = 1'b0;
    end
  end

  // ---------------- policy register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pol <= POL_FIRST;
    end else if (cfg_valid) begin
      pol <= fit_policy;
    end
  end

  // ---------------- item capture ----------------
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= kind;
      need   <= ({1'b0, request_size} + SZ_W'(3)) & ~SZ_W'(3);
      off_r  <= {1'b0, payload_offset};
    end
  end

  // ---------------- scan over live entries ----------------
  assign fits = rdata.free && (rdata.size >= need);
  assign take = fits && (!have ||
                         ((pol == POL_BEST)  && (rdata.size < psize)) ||
                         ((pol == POL_WORST) && (rdata.size > psize)));
  assign hit  = !found && ((rdata.start + HDR) == off_r);
  assign grab_nxt = found && !nxt_ok && ({1'b0, rd_idx} == ({1'b0, cidx} + CNT_ONE));

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_scan <= 1'b0;
    end else begin
      rd_scan <= scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_issue) begin
      rd_idx <= scan_idx[IDX_W-1:0];
    end
    if (cmd.accept) begin
      scan_idx <= '0;
      have     <= 1'b0;
      found    <= 1'b0;
      nxt_ok   <= 1'b0;
    end else begin
      if (scan_issue) begin
        scan_idx <= scan_idx + CNT_ONE;
      end
      if (rd_scan) begin
        last <= rdata;
        if (take) begin
          have   <= 1'b1;
          pidx   <= rd_idx;
          pstart <= rdata.start;
          psize  <= rdata.size;
        end
        if (hit) begin
          found   <= 1'b1;
          cidx    <= rd_idx;
          cur     <= rdata;
          prev    <= last;
          prev_ok <= (rd_idx != '0);
        end
        if (grab_nxt) begin
          nxt_ok <= 1'b1;
          nxt    <= rdata;
        end
      end
    end
  end

  // ---------------- split / merge decision ----------------
  assign pidx_e = {1'b0, pidx};
  assign cidx_e = {1'b0, cidx};
  assign rem    = psize - need;
  assign split  = (rem > SPLIT_MIN) && (count < CNT_MAX);
  assign mrg_n  = nxt_ok && nxt.free;
  assign mrg_p  = prev_ok && prev.free;
  assign sz_n   = cur.size + GAP + nxt.size;
  assign sz_p   = prev.size + GAP + cur.size;
  assign sz_pn  = sz_p + GAP + nxt.size;
  assign fail   = (kind_r == KIND_FREE) ? (!found || cur.free) : !have;

  always_comb begin
    main_addr_d = pidx;
    main_d      = '{start: pstart, size: (split ? need : psize), free: 1'b0};
    new_addr_d  = IDX_W'(pidx_e + CNT_ONE);
    new_d       = '{start: pstart + GAP + need, size: rem - GAP, free: 1'b1};
    mv_src_d    = IDX_W'(count - CNT_ONE);
    mv_left_d   = '0;
    mv_up_d     = 1'b1;
    mv_two_d    = 1'b0;
    count_d     = count;
    total_d     = total;
    res_off_d   = '0;
    res_st_d    = ST_DONE;
    if (kind_r == KIND_ALLOC) begin
      res_off_d = FLD_W'(pstart + HDR);
      total_d   = total + FLD_W'(split ? need : psize);
      if (split) begin
        mv_left_d = count - CNT_ONE - pidx_e;
        count_d   = count + CNT_ONE;
      end
      if (fail) begin
        res_st_d  = ST_NOFIT;
        res_off_d = '0;
      end
    end else begin
      total_d = total - FLD_W'(cur.size);
      mv_up_d = 1'b0;
      if (mrg_p) begin
        main_addr_d = IDX_W'(cidx_e - CNT_ONE);
        main_d      = '{start: prev.start, size: (mrg_n ? sz_pn : sz_p), free: 1'b1};
      end else begin
        main_addr_d = cidx;
        main_d      = '{start: cur.start, size: (mrg_n ? sz_n : cur.size), free: 1'b1};
      end
      if (mrg_n) begin
        mv_src_d  = IDX_W'(cidx_e + CNT_TWO);
        mv_left_d = count - cidx_e - CNT_TWO;
        mv_two_d  = mrg_p;
      end else if (mrg_p) begin
        mv_src_d  = IDX_W'(cidx_e + CNT_ONE);
        mv_left_d = count - cidx_e - CNT_ONE;
      end else begin
        mv_left_d = '0;
      end
      count_d = count - CNT_W'(mrg_n) - CNT_W'(mrg_p);
      if (fail) begin
        res_st_d = ST_BADFREE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_off <= '0;
      res_st  <= ST_ZERO;
    end else if (cmd.decide) begin
      res_off   <= res_off_d;
      res_st    <= res_st_d;
      main_addr <= main_addr_d;
      main_e    <= main_d;
      new_addr  <= new_addr_d;
      new_e     <= new_d;
    end
  end

  // count and running total
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CNT_ONE;
      total <= '0;
    end else if (cmd.decide && !fail) begin
      count <= count_d;
      total <= total_d;
    end
  end

  // ---------------- entry shift engine ----------------
  always_comb begin
    priority if (mv_up) mv_dst = mv_src + IDX_W'(1);
    else if (mv_two) mv_dst = mv_src - IDX_W'(2);
    else mv_dst = mv_src - IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend    <= 1'b0;
      mv_left <= '0;
    end else begin
      pend <= mv_issue;
      if (cmd.decide) begin
        mv_left <= fail ? '0 : mv_left_d;
      end else if (mv_issue) begin
        mv_left <= mv_left - CNT_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      mv_src <= mv_src_d;
      mv_up  <= mv_up_d;
      mv_two <= mv_two_d;
    end else if (mv_issue) begin
      mv_src    <= mv_up ? (mv_src - IDX_W'(1)) : (mv_src + IDX_W'(1));
      pend_addr <= mv_dst;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result_offset   <= res_off;
      status          <= res_st;
      allocated_total <= total;
    end
  end

  // ---------------- status ----------------
  always_comb begin
    sts           = '0;
    sts.zero_in   = (kind == KIND_ALLOC) && (request_size == '0);
    sts.scan_done = rd_scan && ({1'b0, rd_idx} == (count - CNT_ONE));
    sts.fail      = fail;
    sts.split     = split;
    sts.is_alloc  = (kind_r == KIND_ALLOC);
    sts.mv_done   = (mv_left == '0) && !pend;
    sts.out_free  = !out_valid || !out_stall;
  end

`ifndef SYNTHESIS
  // the table always holds at least one block and never more than it can
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count != '0) && (count <= CNT_MAX))
    else $error("block count out of range");

  // a rejected item leaves the table size alone
  a_fail_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.decide && fail) |=> (count == $past(count)))
    else $error("count changed on a rejected item");

  // no shift transfer while a scan read is in flight
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(scan_issue && mv_issue) && !(rd_scan && pend))
    else $error("scan and shift overlap on the table port");

  // allocated bytes never exceed the heap
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, total} <= SZ_W'(HEAP_BYTES))
    else $error("allocated total exceeds heap");
`endif

endmodule

FILE: design/fit_policy_heap_allocator_unit.sv
// ----------------------------------------------------------------------------
// fit_policy_heap_allocator_unit
// Boundary-tag heap allocator with first, best and worst fit placement.
// ----------------------------------------------------------------------------
// The one-read, one-write table memory is scanned and shifted one entry per
//   cycle, so an item takes longer with more live table entries and more
//   shifted entries; an allocate with a split also writes a new free entry.
// Throughput: one item at a time; the next is taken once the result is loaded.
// Zero-size allocate: answered without a scan. Reset: synchronous; a fill
//   state writes the initial free block, then the unit accepts items.
module fit_policy_heap_allocator_unit #(
  parameter int HEAP_BYTES   = 67108864,
  parameter int HEADER_BYTES = 32,
  parameter int TAG_BYTES    = 8,
  parameter int MAX_BLOCKS   = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       kind,
  input  logic [fpha_pkg::FLD_W-1:0] request_size,
  input  logic [fpha_pkg::FLD_W-1:0] payload_offset,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [fpha_pkg::FLD_W-1:0] result_offset,
  output logic [1:0]                 status,
  output logic [fpha_pkg::FLD_W-1:0] allocated_total,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 fit_policy
);
  import fpha_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // policy register takes a write on any cycle
  assign cfg_ready = 1'b1;

  fpha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fpha_dpath #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .TAG_BYTES    (TAG_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_valid       (cfg_valid && cfg_ready),
    .fit_policy      (fit_policy),
    .kind            (kind),
    .request_size    (request_size),
    .payload_offset  (payload_offset),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .result_offset   (result_offset),
    .status          (status),
    .allocated_total (allocated_total)
  );

endmodule
